// ===== rtl/core/its_pkg.sv =====
// ----------------------------------------------------------------------------
// its_pkg: shared definitions for the telemetry slave
// widths, command codes, reply framing bytes and register reset values
// ----------------------------------------------------------------------------
package its_pkg;

	// sensor slots, numbered from 1
	localparam int SLOT_MAX   = 5;
	localparam int SLOT_COUNT = 5;
	localparam int SLOT_W     = $clog2(SLOT_MAX);

	// configuration port
	localparam int CFG_IDX_W  = SLOT_W;
	localparam int CFG_DATA_W = 8;

	// reply buffer
	localparam int REPLY_MAX  = 8;
	localparam int RCNT_W     = $clog2(REPLY_MAX + 1);
	localparam int BODY_MAX   = REPLY_MAX - 2;

	// request framing
	localparam int REQ_CNT_W  = 2;

	// slave side payload layout
	localparam int RXB_LO     = 0;
	localparam int SIDX_LO    = 8;
	localparam int SVAL_LO    = 12;
	localparam int S_TDATA_W  = 48;

	typedef logic [7:0] byte_t;

	// command nibble
	localparam logic [3:0] CMD_ECHO  = 4'h8;
	localparam logic [3:0] CMD_INFO  = 4'h9;
	localparam logic [3:0] CMD_VALUE = 4'hA;

	// framing bytes
	localparam byte_t LEN_REQ   = 8'h04;
	localparam byte_t LEN_SHORT = 8'h06;
	localparam byte_t LEN_LONG  = 8'h08;
	localparam byte_t SIZE_2B   = 8'h02;
	localparam byte_t SIZE_4B   = 8'h04;

	localparam logic [15:0] CHK_SEED = 16'hFFFF;
	localparam int TYPE_WIDE_BIT = 7;

	localparam byte_t TYPE_RESET [SLOT_MAX] = '{8'd3, 8'd1, 8'd9, 8'd131, 8'd132};

endpackage

// ===== rtl/core/ibus_telemetry_slave_unit.sv =====
// ----------------------------------------------------------------------------
// ibus_telemetry_slave_unit: telemetry slave of a half-duplex sensor bus
// frames 4-byte requests, checks them and builds 4/6/8-byte replies
// ----------------------------------------------------------------------------
// a request's last byte is registered in the input stage, then its reply loads the reply buffer
// throughput: one request per cycle, only the byte that closes an answered
// request waits, and only while an earlier reply is still draining
// a reply leaves at one byte per cycle while m_tready is high, from the single reply shift
// buffer, which reloads as its last byte leaves
// reset (arst_n low): framing restarts, slot values clear, types take defaults
module ibus_telemetry_slave_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	// slave side: bus bytes and sensor value updates
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// rx_byte [7:0], slot_index [11:8], slot_value [43:12], zero [47:44]
	input  logic [its_pkg::S_TDATA_W-1:0] s_tdata,
	// kind [0]: 0 bus byte, 1 value update
	input  logic                          s_tuser,
	// master side: reply bytes
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// tx_byte [7:0]
	output logic [7:0]                    m_tdata,
	// last_byte of a reply
	output logic                          m_tlast,
	// configuration write port
	input  logic                          cfg_wen,
	input  logic [its_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [its_pkg::CFG_DATA_W-1:0] cfg_wdata
);

	// input stage
	logic                  s1_valid;
	logic                  kind_s1;
	its_pkg::byte_t        rxb_s1;
	logic [3:0]            sidx_s1;
	logic [31:0]           sval_s1;
	logic                  s1_adv;

	// block state
	logic [its_pkg::REQ_CNT_W-1:0] cnt_q;
	logic [its_pkg::REQ_CNT_W-1:0] cnt_d;
	its_pkg::byte_t                req1_q;   // command byte
	its_pkg::byte_t                req2_q;   // checksum low byte
	its_pkg::byte_t                types_q  [its_pkg::SLOT_MAX];
	logic [31:0]                   values_q [its_pkg::SLOT_MAX];

	// reply buffer, byte 0 is on the bus
	its_pkg::byte_t                rbuf_q [its_pkg::REPLY_MAX];
	logic [its_pkg::RCNT_W-1:0]    rcnt_q;
	logic                          buf_free;
	logic                          m_take;

	// decode of the item in the input stage
	logic                          upd_hit;
	logic [its_pkg::SLOT_W-1:0]    upd_slot;
	logic                          bus_item;
	logic [15:0]                   req_chk;
	logic                          chk_ok;
	logic [3:0]                    slot_nib;
	logic                          slot_ok;
	logic [its_pkg::SLOT_W-1:0]    rd_slot;
	its_pkg::byte_t                rd_type;
	logic [31:0]                   rd_val;
	logic                          cmd_ok;
	its_pkg::byte_t                body [its_pkg::BODY_MAX];
	logic [its_pkg::RCNT_W-1:0]    rlen;
	logic [15:0]                   body_sum;
	logic [15:0]                   rchk;
	its_pkg::byte_t                rbuf_d [its_pkg::REPLY_MAX];
	logic                          has_reply;

	// ---------------------------------------------------------------- handshakes
	assign m_take   = m_tvalid && m_tready;
	// buffer can take a new reply now or as its last byte leaves
	assign buf_free = (rcnt_q == '0) ||
	                  ((rcnt_q == its_pkg::RCNT_W'(1)) && m_tready);
	// an item with no reply never waits on the master side
	assign s1_adv   = s1_valid && (!has_reply || buf_free);
	assign s_tready = !s1_valid || s1_adv;

	// ---------------------------------------------------------------- input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid <= 1'b0;
		end else if (s_tready) begin
			s1_valid <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			kind_s1 <= s_tuser;
			rxb_s1  <= s_tdata[its_pkg::RXB_LO +: 8];
			sidx_s1 <= s_tdata[its_pkg::SIDX_LO +: 4];
			sval_s1 <= s_tdata[its_pkg::SVAL_LO +: 32];
		end
	end

	// ---------------------------------------------------------------- value updates
	assign upd_hit  = kind_s1 && (sidx_s1 != 4'd0) &&
	                  (sidx_s1 <= 4'(its_pkg::SLOT_COUNT));
	assign upd_slot = sidx_s1[its_pkg::SLOT_W-1:0] - its_pkg::SLOT_W'(1);

	// ---------------------------------------------------------------- request framing
	assign bus_item = !kind_s1;

	// count 0 waits for the length byte, 1..2 collect command and checksum low,
	// 3 means the current byte closes the request
	always_comb begin
		cnt_d = cnt_q;
		if (bus_item) begin
			if (cnt_q == '0) begin
				cnt_d = (rxb_s1 == its_pkg::LEN_REQ) ? its_pkg::REQ_CNT_W'(1) : '0;
			end else if (cnt_q == its_pkg::REQ_CNT_W'(3)) begin
				cnt_d = '0;
			end else begin
				cnt_d = cnt_q + its_pkg::REQ_CNT_W'(1);
			end
		end
	end

	// request checksum over the length byte and the command byte
	assign req_chk  = its_pkg::CHK_SEED - {8'h00, its_pkg::LEN_REQ} - {8'h00, req1_q};
	assign chk_ok   = (req2_q == req_chk[7:0]) && (rxb_s1 == req_chk[15:8]);

	assign slot_nib = req1_q[3:0];
	assign slot_ok  = (slot_nib != 4'd0) && (slot_nib <= 4'(its_pkg::SLOT_COUNT));
	assign rd_slot  = slot_nib[its_pkg::SLOT_W-1:0] - its_pkg::SLOT_W'(1);
	assign rd_type  = types_q[rd_slot];
	assign rd_val   = values_q[rd_slot];

	// ---------------------------------------------------------------- reply build
	always_comb begin
		for (int i = 0; i < its_pkg::BODY_MAX; i++) begin
			body[i] = '0;
		end
		rlen    = '0;
		cmd_ok  = 1'b1;
		body[1] = req1_q;
		case (req1_q[7:4])
			its_pkg::CMD_ECHO: begin
				body[0] = its_pkg::LEN_REQ;
				rlen    = its_pkg::RCNT_W'(4);
			end
			its_pkg::CMD_INFO: begin
				body[0] = its_pkg::LEN_SHORT;
				body[2] = rd_type;
				body[3] = rd_type[its_pkg::TYPE_WIDE_BIT] ? its_pkg::SIZE_4B : its_pkg::SIZE_2B;
				rlen    = its_pkg::RCNT_W'(6);
			end
			its_pkg::CMD_VALUE: begin
				body[2] = rd_val[7:0];
				body[3] = rd_val[15:8];
				if (rd_type[its_pkg::TYPE_WIDE_BIT]) begin
					body[0] = its_pkg::LEN_LONG;
					body[4] = rd_val[23:16];
					body[5] = rd_val[31:24];
					rlen    = its_pkg::RCNT_W'(8);
				end else begin
					body[0] = its_pkg::LEN_SHORT;
					rlen    = its_pkg::RCNT_W'(6);
				end
			end
			default: begin
				cmd_ok = 1'b0;
			end
		endcase
	end

	// unused body bytes are zero, so summing all of them is safe
	always_comb begin
		body_sum = '0;
		for (int i = 0; i < its_pkg::BODY_MAX; i++) begin
			body_sum = body_sum + {8'h00, body[i]};
		end
	end
	assign rchk = its_pkg::CHK_SEED - body_sum;

	// checksum lands right after the body, low byte first
	always_comb begin
		for (int i = 0; i < its_pkg::REPLY_MAX; i++) begin
			if (its_pkg::RCNT_W'(i) == rlen - its_pkg::RCNT_W'(2)) begin
				rbuf_d[i] = rchk[7:0];
			end else if (its_pkg::RCNT_W'(i) == rlen - its_pkg::RCNT_W'(1)) begin
				rbuf_d[i] = rchk[15:8];
			end else if (i < its_pkg::BODY_MAX) begin
				rbuf_d[i] = body[i];
			end else begin
				rbuf_d[i] = '0;
			end
		end
	end

	assign has_reply = bus_item && (cnt_q == its_pkg::REQ_CNT_W'(3)) &&
	                   chk_ok && slot_ok && cmd_ok;

	// ---------------------------------------------------------------- state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			for (int i = 0; i < its_pkg::SLOT_MAX; i++) begin
				types_q[i]  <= its_pkg::TYPE_RESET[i];
				values_q[i] <= '0;
			end
		end else begin
			if (s1_adv) begin
				cnt_q <= cnt_d;
				if (upd_hit) begin
					values_q[upd_slot] <= sval_s1;
				end
			end
			// the user must write config only while idle, the block itself does not enforce it
			if (cfg_wen && (cfg_index < its_pkg::CFG_IDX_W'(its_pkg::SLOT_MAX))) begin
				types_q[cfg_index] <= cfg_wdata;
			end
		end
	end

	// request bytes need no reset, each is written before it is read
	always_ff @(posedge clk) begin
		if (s1_adv && bus_item) begin
			if (cnt_q == its_pkg::REQ_CNT_W'(1)) begin
				req1_q <= rxb_s1;
			end
			if (cnt_q == its_pkg::REQ_CNT_W'(2)) begin
				req2_q <= rxb_s1;
			end
		end
	end

	// ---------------------------------------------------------------- reply buffer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rcnt_q <= '0;
		end else if (s1_adv && has_reply) begin
			rcnt_q <= rlen;
		end else if (m_take) begin
			rcnt_q <= rcnt_q - its_pkg::RCNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv && has_reply) begin
			rbuf_q <= rbuf_d;
		end else if (m_take) begin
			for (int i = 0; i < its_pkg::REPLY_MAX - 1; i++) begin
				rbuf_q[i] <= rbuf_q[i+1];
			end
		end
	end

	assign m_tvalid = (rcnt_q != '0);
	assign m_tdata  = rbuf_q[0];
	assign m_tlast  = (rcnt_q == its_pkg::RCNT_W'(1));

endmodule

// ===== rtl/core/its_checker.sv =====
// ----------------------------------------------------------------------------
// its_checker: port-level checks for the telemetry slave
// watches reply framing and the stall behavior seen on the ports
// ----------------------------------------------------------------------------
module its_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           s_tready,
	input logic                           m_tvalid,
	input logic                           m_tready,
	input logic [7:0]                     m_tdata,
	input logic                           m_tlast
);

	// high while the next reply byte opens a new reply
	logic first_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_q <= 1'b1;
		end else if (m_tvalid && m_tready) begin
			first_q <= m_tlast;
		end
	end

	// nothing is offered during reset
	a_reset_quiet: assert property (@(posedge clk) !arst_n |-> !m_tvalid)
		else $error("reply byte offered during reset");

	// a stalled reply byte holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("stalled reply byte changed");

	// reply bytes follow each other with no gap
	a_no_gap: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && !m_tlast |=> m_tvalid)
		else $error("gap inside a reply");

	// every reply opens with a legal length byte
	a_len_byte: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && first_q |->
			(m_tdata == its_pkg::LEN_REQ) || (m_tdata == its_pkg::LEN_SHORT) ||
			(m_tdata == its_pkg::LEN_LONG))
		else $error("reply opens with a bad length byte");

	// with no reply pending the slave side is never blocked
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled with an empty reply buffer");

endmodule

bind ibus_telemetry_slave_unit its_checker u_its_checker (.*);

// ===== tb/sv/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench: self-checking bench for ibus_telemetry_slave_unit
// drives bus bytes and sensor updates on the slave stream, predicts every
// reply byte from an internal model of the slave and checks the master stream
// ----------------------------------------------------------------------------
module testbench;

	// slave side kind flag
	localparam logic KIND_BYTE   = 1'b0;
	localparam logic KIND_UPDATE = 1'b1;

	// command nibble the slave does not know
	localparam logic [3:0] CMD_UNKNOWN = 4'hF;

	localparam int RAND_ITEMS     = 24;
	localparam int RAND_SEG       = 12;
	localparam int BP_POLLS       = 4;
	localparam int RX_HOLD_CYCLES = 120;
	localparam int SETTLE_CYCLES  = 12;
	localparam int MAX_SHOWN      = 50;

	typedef struct packed {
		its_pkg::byte_t data;
		logic           is_last;
	} tx_byte_t;

	logic                             clk;
	logic                             arst_n;
	logic                             s_tvalid;
	logic                             s_tready;
	// rx_byte [7:0], slot_index [11:8], slot_value [43:12], zero [47:44]
	logic [its_pkg::S_TDATA_W-1:0]    s_tdata;
	// kind [0]
	logic                             s_tuser;
	logic                             m_tvalid;
	logic                             m_tready;
	// tx_byte [7:0]
	logic [7:0]                       m_tdata;
	logic                             m_tlast;
	logic                             cfg_wen;
	logic [its_pkg::CFG_IDX_W-1:0]    cfg_index;
	logic [its_pkg::CFG_DATA_W-1:0]   cfg_wdata;

	// slave model state
	its_pkg::byte_t type_m [its_pkg::SLOT_MAX];
	logic [31:0]    value_m [its_pkg::SLOT_MAX];
	its_pkg::byte_t poll_buf [4];
	bit             in_frame;
	logic [2:0]     frame_cnt;

	// reply bytes still owed by the block, oldest first
	tx_byte_t pending_tx [$];

	// shared run controls
	bit idle_on;
	int rx_hold;
	int err_count;
	int items_sent;
	int tx_seen;
	int cfg_writes;

	ibus_telemetry_slave_unit u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.cfg_wen   (cfg_wen),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// hard stop in case the block hangs
	initial begin
		#1000000;
		$display("Regression FAIL");
		$finish;
	end

	task automatic report_mismatch(input string msg);
		if (err_count < MAX_SHOWN)
			$display("mismatch at %0t: %s", $realtime, msg);
		err_count++;
	endtask

	// ------------------------------------------------------------------------
	// slave model
	// ------------------------------------------------------------------------

	function automatic logic [15:0] poll_chk(input its_pkg::byte_t cmd);
		return its_pkg::CHK_SEED - its_pkg::LEN_REQ - cmd;
	endfunction

	// answer a complete 4-byte poll, queueing its reply bytes
	task automatic build_reply();
		its_pkg::byte_t rep [its_pkg::REPLY_MAX];
		logic [15:0]    chk;
		logic [3:0]     slot;
		its_pkg::byte_t ty;
		logic [31:0]    val;
		tx_byte_t       e;
		int             n;
		int             i;
		chk = its_pkg::CHK_SEED - poll_buf[0] - poll_buf[1];
		slot = poll_buf[1][3:0];
		// bad checksum: dropped silently
		if (poll_buf[2] != chk[7:0] || poll_buf[3] != chk[15:8])
			return;
		// slot 0 or beyond the last slot: no reply
		if (slot < 1 || slot > its_pkg::SLOT_COUNT)
			return;
		ty = type_m[slot - 1];
		val = value_m[slot - 1];
		rep[1] = poll_buf[1];
		case (poll_buf[1][7:4])
			its_pkg::CMD_ECHO: begin
				rep[0] = poll_buf[0];
				n = 4;
			end
			its_pkg::CMD_INFO: begin
				rep[0] = its_pkg::LEN_SHORT;
				rep[2] = ty;
				rep[3] = ty[its_pkg::TYPE_WIDE_BIT] ? its_pkg::SIZE_4B : its_pkg::SIZE_2B;
				n = 6;
			end
			its_pkg::CMD_VALUE: begin
				rep[2] = val[7:0];
				rep[3] = val[15:8];
				if (ty[its_pkg::TYPE_WIDE_BIT]) begin
					rep[0] = its_pkg::LEN_LONG;
					rep[4] = val[23:16];
					rep[5] = val[31:24];
					n = 8;
				end else begin
					rep[0] = its_pkg::LEN_SHORT;
					n = 6;
				end
			end
			default: return;
		endcase
		chk = its_pkg::CHK_SEED;
		for (i = 0; i < n - 2; i++)
			chk = chk - rep[i];
		rep[n - 2] = chk[7:0];
		rep[n - 1] = chk[15:8];
		for (i = 0; i < n; i++) begin
			e.data = rep[i];
			e.is_last = (i == n - 1);
			pending_tx.push_back(e);
		end
	endtask

	// advance the model by one accepted slave request
	task automatic track_item(input logic kind, input its_pkg::byte_t rxb,
			input logic [3:0] sidx, input logic [31:0] sval);
		if (kind == KIND_UPDATE) begin
			// updates to missing slots are ignored, framing is untouched
			if (sidx >= 1 && sidx <= its_pkg::SLOT_COUNT)
				value_m[sidx - 1] = sval;
		end else if (!in_frame) begin
			// anything but the length byte is dropped while hunting
			if (rxb == its_pkg::LEN_REQ) begin
				poll_buf[0] = rxb;
				frame_cnt = 3'd1;
				in_frame = 1'b1;
			end else begin
				frame_cnt = 3'd0;
			end
		end else begin
			poll_buf[frame_cnt[1:0]] = rxb;
			frame_cnt = frame_cnt + 3'd1;
			if (frame_cnt >= 3'd4) begin
				in_frame = 1'b0;
				frame_cnt = 3'd0;
				build_reply();
			end
		end
	endtask

	// ------------------------------------------------------------------------
	// drivers
	// ------------------------------------------------------------------------

	// one slave request, with a random lead-in gap when idling is on
	task automatic send_item(input logic kind, input its_pkg::byte_t rxb,
			input logic [3:0] sidx, input logic [31:0] sval);
		int gap;
		gap = idle_on ? $urandom_range(0, 6) : 0;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= kind;
		s_tdata <= {4'b0, sval, sidx, rxb};
		do @(posedge clk); while (!s_tready);
		track_item(kind, rxb, sidx, sval);
		items_sent++;
	endtask

	// bus byte, unused fields carry noise
	task automatic send_byte(input its_pkg::byte_t b);
		logic [3:0] junk_idx;
		junk_idx = 4'($urandom_range(0, 15));
		send_item(KIND_BYTE, b, junk_idx, $urandom);
	endtask

	// value update, unused byte carries noise
	task automatic send_update(input logic [3:0] sidx, input logic [31:0] sval);
		its_pkg::byte_t junk;
		junk = 8'($urandom);
		send_item(KIND_UPDATE, junk, sidx, sval);
	endtask

	// full poll, optionally with a broken checksum or an update in the middle
	task automatic send_poll(input its_pkg::byte_t cmd, input bit bad_chk, input bit mid_upd);
		logic [15:0] chk;
		logic [15:0] flip;
		logic [3:0]  sidx;
		chk = poll_chk(cmd);
		if (bad_chk) begin
			flip = 16'($urandom_range(1, 65535));
			chk = chk ^ flip;
		end
		send_byte(its_pkg::LEN_REQ);
		send_byte(cmd);
		if (mid_upd) begin
			sidx = 4'($urandom_range(0, 15));
			send_update(sidx, $urandom);
		end
		send_byte(chk[7:0]);
		send_byte(chk[15:8]);
	endtask

	// register write, only called with the block idle
	task automatic write_type(input int idx, input its_pkg::byte_t val);
		cfg_wen <= 1'b1;
		cfg_index <= its_pkg::CFG_IDX_W'(idx);
		cfg_wdata <= val;
		@(posedge clk);
		// indexes past the last slot do nothing
		if (idx < its_pkg::SLOT_MAX)
			type_m[idx] = val;
		cfg_writes++;
		cfg_wen <= 1'b0;
		@(posedge clk);
	endtask

	// stop sending and let every owed reply byte drain
	task automatic wait_drain();
		s_tvalid <= 1'b0;
		while (pending_tx.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic logic [3:0] rand_slot();
		logic [3:0] s;
		if ($urandom_range(0, 9) < 8)
			s = 4'($urandom_range(1, its_pkg::SLOT_COUNT));
		else
			s = 4'($urandom_range(0, 15));
		return s;
	endfunction

	function automatic its_pkg::byte_t rand_cmd();
		logic [3:0] op;
		case ($urandom_range(0, 9)) inside
			[0:2]: op = its_pkg::CMD_ECHO;
			[3:5]: op = its_pkg::CMD_INFO;
			[6:8]: op = its_pkg::CMD_VALUE;
			default: op = 4'($urandom_range(0, 15));
		endcase
		return {op, rand_slot()};
	endfunction

	// type codes weighted toward the edges of the wide bit
	function automatic its_pkg::byte_t pick_type();
		its_pkg::byte_t t;
		case ($urandom_range(0, 7))
			0: t = 8'h00;
			1: t = 8'hFF;
			2: t = 8'h7F;
			3: t = 8'h80;
			default: t = 8'($urandom);
		endcase
		return t;
	endfunction

	// ------------------------------------------------------------------------
	// receiver: random stalls per reply byte, plus a long hold on demand
	// ------------------------------------------------------------------------
	initial begin : rx_side
		int n;
		m_tready = 1'b0;
		@(posedge clk);
		while (!arst_n)
			@(posedge clk);
		forever begin
			if (rx_hold > 0) begin
				n = rx_hold;
				rx_hold = 0;
			end else begin
				n = idle_on ? $urandom_range(0, 6) : 0;
			end
			if (n > 0) begin
				m_tready <= 1'b0;
				repeat (n) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
		end
	end

	// ------------------------------------------------------------------------
	// reply checker: each accepted byte against the oldest owed byte
	// ------------------------------------------------------------------------
	always @(posedge clk) begin : tx_check
		tx_byte_t want;
		if (arst_n && m_tvalid && m_tready) begin
			tx_seen++;
			if (pending_tx.size() == 0) begin
				report_mismatch($sformatf("unexpected reply byte %02h last %0b",
					m_tdata, m_tlast));
			end else begin
				want = pending_tx.pop_front();
				if (m_tdata !== want.data)
					report_mismatch($sformatf("tx_byte %02h, wanted %02h", m_tdata, want.data));
				if (m_tlast !== want.is_last)
					report_mismatch($sformatf("last_byte %0b, wanted %0b on byte %02h",
						m_tlast, want.is_last, want.data));
			end
		end
	end

	// ------------------------------------------------------------------------
	// tests
	// ------------------------------------------------------------------------

	// field extremes, every command, the bad checksum, slot 0 and unknown command drops, reset type codes
	task automatic test_directed();
		logic [15:0] chk;
		send_update(4'd0, 32'h0000_0000);     // no slot 0
		send_update(4'hF, 32'hFFFF_FFFF);     // no slot 15
		send_update(4'd2, 32'hA5C3_0F81);
		send_byte(8'h00);                     // not a length byte
		send_byte(8'hFF);
		send_poll({its_pkg::CMD_ECHO, 4'd1}, 1'b0, 1'b0);
		send_poll({its_pkg::CMD_INFO, 4'd5}, 1'b0, 1'b0);
		// wide read, slot written between command and checksum
		chk = poll_chk({its_pkg::CMD_VALUE, 4'd4});
		send_byte(its_pkg::LEN_REQ);
		send_byte({its_pkg::CMD_VALUE, 4'd4});
		send_update(4'd4, 32'hFFFF_FFFF);
		send_byte(chk[7:0]);
		send_byte(chk[15:8]);
		send_poll({its_pkg::CMD_VALUE, 4'd2}, 1'b0, 1'b0);   // short read, low half only
		send_poll({its_pkg::CMD_VALUE, 4'd1}, 1'b1, 1'b0);   // checksum broken
		send_poll({its_pkg::CMD_ECHO, 4'd0}, 1'b0, 1'b0);    // slot 0
		send_poll({CMD_UNKNOWN, 4'd3}, 1'b0, 1'b0);          // unknown command
	endtask

	// all-zero, all-ones, split around the wide bit, then random codes
	task automatic test_type_registers();
		int             ph;
		int             s;
		its_pkg::byte_t t;
		logic [3:0]     slot_n;
		logic [3:0]     op;
		for (ph = 0; ph < 4; ph++) begin
			wait_drain();
			for (s = 0; s < its_pkg::SLOT_MAX; s++) begin
				case (ph)
					0: t = 8'h00;
					1: t = 8'hFF;
					2: t = s[0] ? 8'h80 : 8'h7F;
					default: t = pick_type();
				endcase
				write_type(s, t);
			end
			// index past the last slot, must not disturb anything
			write_type(its_pkg::SLOT_MAX + $urandom_range(0, 2), 8'($urandom));
			for (s = 1; s <= its_pkg::SLOT_COUNT; s++) begin
				slot_n = 4'(s);
				op = $urandom_range(0, 1) ? its_pkg::CMD_INFO : its_pkg::CMD_VALUE;
				// fresh value ahead of a value read
				if (op == its_pkg::CMD_VALUE)
					send_update(slot_n, $urandom);
				send_poll({op, slot_n}, 1'b0, 1'b0);
			end
		end
	endtask

	// mostly well-formed polls with random content, some noise and damage
	task automatic test_random_traffic();
		int         counted;
		int         seg;
		int         r;
		int         s;
		logic [3:0] sidx;
		counted = 0;
		seg = 0;
		while (counted < RAND_ITEMS) begin
			if (counted >= (seg + 1) * RAND_SEG) begin
				seg++;
				// sender pause, then new type codes
				wait_drain();
				for (s = 0; s < its_pkg::SLOT_MAX; s++)
					write_type(s, pick_type());
				// one stretch runs with no idling on either side
				idle_on = (seg != 1);
			end
			r = $urandom_range(0, 99);
			if (r < 8) begin
				send_byte(8'($urandom));
			end else if (r < 18) begin
				sidx = rand_slot();
				send_update(sidx, $urandom);
				if (sidx >= 1 && sidx <= its_pkg::SLOT_COUNT)
					counted++;
			end else begin
				send_poll(rand_cmd(), r < 25, $urandom_range(0, 9) == 0);
				counted += 4;
			end
		end
		idle_on = 1'b1;
	endtask

	// receiver holds off while polls keep coming, so the input backs up
	task automatic test_backpressure();
		int         k;
		logic [3:0] slot_n;
		wait_drain();
		idle_on = 1'b0;
		rx_hold = RX_HOLD_CYCLES;
		for (k = 0; k < BP_POLLS; k++) begin
			slot_n = 4'($urandom_range(1, its_pkg::SLOT_COUNT));
			send_poll({(k[0] ? its_pkg::CMD_ECHO : its_pkg::CMD_VALUE), slot_n}, 1'b0, 1'b0);
		end
		wait_drain();
		idle_on = 1'b1;
	endtask

	// ------------------------------------------------------------------------
	// main sequence
	// ------------------------------------------------------------------------
	initial begin : main_seq
		int i;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = 1'b0;
		cfg_wen = 1'b0;
		cfg_index = '0;
		cfg_wdata = '0;
		idle_on = 1'b1;
		rx_hold = 0;
		err_count = 0;
		items_sent = 0;
		tx_seen = 0;
		cfg_writes = 0;
		// model reset state
		for (i = 0; i < its_pkg::SLOT_MAX; i++) begin
			type_m[i] = its_pkg::TYPE_RESET[i];
			value_m[i] = '0;
		end
		for (i = 0; i < 4; i++)
			poll_buf[i] = '0;
		in_frame = 1'b0;
		frame_cnt = '0;

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_type_registers();
		test_random_traffic();
		test_backpressure();
		wait_drain();

		$display("covered %0d slave requests, %0d reply bytes, %0d type register writes",
			items_sent, tx_seen, cfg_writes);
		$display("echo, info and value polls under four type settings, damage and a long hold");
		if (err_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
